@@ rtl/core/idalloc_pkg.sv @@
// shared constants, codes, types and the row search function of the id allocator
package idalloc_pkg;

  localparam int POOL_SIZE = 64;
  localparam int ID_W      = $clog2(POOL_SIZE);
  localparam int CNT_W     = ID_W + 1;
  localparam int ROW_W     = 8;
  localparam int COL_AW    = $clog2(ROW_W);
  localparam int ROWS      = POOL_SIZE / ROW_W;
  localparam int ROW_AW    = $clog2(ROWS);

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_CLAIM   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INACTIVE  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_QFULL     = 2'd3
  } status_t;

  // single-bit update of the active map
  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] row;
    logic [COL_AW-1:0] col;
    logic              val;
  } amap_wr_t;

  typedef struct packed {
    logic              found;
    logic [COL_AW-1:0] col;
  } free_pos_t;

  // lowest clear bit at or above off
  function automatic free_pos_t first_free(input logic [ROW_W-1:0] row,
                                           input logic [COL_AW-1:0] off);
    free_pos_t r;
    r.found = 1'b0;
    r.col   = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if ((COL_AW'(i) >= off) && !row[i]) begin
        r.found = 1'b1;
        r.col   = COL_AW'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/id_allocator_with_recycle_queue_top.sv @@
// id allocator top: request sequencer, queue pointers, fresh-id scan and result register
//
//   port group   dir  handshake            word
//   in_*         in   in_valid/in_ready    in_action, in_request_id
//   out_*        out  out_valid/out_ready  out_result_id, out_status
//
// claim, release and allocate from the recycle queue do a memory read, then decide and
// write back. allocate from fresh ids walks the active map memory one row of 8 ids a
// cycle, the longest walk when all 8 rows are full and one more step reports the pool
// exhausted. reset clears the pointers and the 8 row valid bits of the active map,
// with no clearing pass. the result sits in an output register; the next word is taken
// while it waits, and only the final write-back step holds until it drains.
module id_allocator_with_recycle_queue_top import idalloc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_action,
  input  logic [ID_W-1:0] in_request_id,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] out_result_id,
  output logic [1:0]      out_status
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  action_t         act_r;
  logic [ID_W-1:0] rid_r;
  logic [ID_W-1:0] head_r, head_nxt;
  logic [ID_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [ID_W-1:0] out_id_r, out_id_nxt;
  status_t         out_st_r, out_st_nxt;

  logic            accept;
  logic            out_free;
  logic            amap_rd_en;
  logic [ROW_AW-1:0] amap_rd_row;
  amap_wr_t        amap_wr;
  logic [ROW_W-1:0] amap_rdata;
  logic            rq_wr_en;
  logic            rq_rd_en;
  logic [ID_W-1:0] rq_rdata;
  free_pos_t       ff;
  logic [CNT_W-1:0] fresh_row_next;
  logic [ID_W-1:0] fresh_id;

  assign in_ready      = (state_r == S_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_free      = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_result_id = out_id_r;
  assign out_status    = out_st_r;

  assign ff             = first_free(amap_rdata, fresh_r[COL_AW-1:0]);
  assign fresh_row_next = {fresh_r[CNT_W-1:COL_AW] + 1'b1, {COL_AW{1'b0}}};
  assign fresh_id       = {fresh_r[ID_W-1:COL_AW], ff.col};

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    amap_rd_en    = 1'b0;
    amap_rd_row   = in_request_id[ID_W-1:COL_AW];
    amap_wr       = '0;
    rq_wr_en      = 1'b0;
    rq_rd_en      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_EXEC;
          amap_rd_en = 1'b1;
          if (action_t'(in_action) == ACT_ALLOC) begin
            amap_rd_row = fresh_r[ID_W-1:COL_AW];
            rq_rd_en    = 1'b1;
          end
        end
      end
      S_EXEC: begin
        // the id field covers the whole pool, so every request id is inside it
        case (act_r)
          ACT_ALLOC: begin
            if (count_r != '0) begin
              if (out_free) begin
                head_nxt      = head_r + 1'b1;
                count_nxt     = count_r - 1'b1;
                amap_wr       = '{en: 1'b1, row: rq_rdata[ID_W-1:COL_AW],
                                  col: rq_rdata[COL_AW-1:0], val: 1'b1};
                out_valid_nxt = 1'b1;
                out_id_nxt    = rq_rdata;
                out_st_nxt    = ST_OK;
                state_nxt     = S_IDLE;
              end
            end else if (fresh_r[CNT_W-1]) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_id_nxt    = '0;
                out_st_nxt    = ST_EXHAUSTED;
                state_nxt     = S_IDLE;
              end
            end else if (ff.found) begin
              if (out_free) begin
                fresh_nxt     = {1'b0, fresh_id} + 1'b1;
                amap_wr       = '{en: 1'b1, row: fresh_r[ID_W-1:COL_AW],
                                  col: ff.col, val: 1'b1};
                out_valid_nxt = 1'b1;
                out_id_nxt    = fresh_id;
                out_st_nxt    = ST_OK;
                state_nxt     = S_IDLE;
              end
            end else begin
              // row fully active from the counter on: step to the next row
              fresh_nxt = fresh_row_next;
              if (!fresh_row_next[CNT_W-1]) begin
                amap_rd_en  = 1'b1;
                amap_rd_row = fresh_row_next[ID_W-1:COL_AW];
              end
            end
          end
          ACT_CLAIM: begin
            if (out_free) begin
              amap_wr       = '{en: 1'b1, row: rid_r[ID_W-1:COL_AW],
                                col: rid_r[COL_AW-1:0], val: 1'b1};
              out_valid_nxt = 1'b1;
              out_id_nxt    = rid_r;
              out_st_nxt    = ST_OK;
              state_nxt     = S_IDLE;
            end
          end
          ACT_RELEASE: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_id_nxt    = rid_r;
              state_nxt     = S_IDLE;
              if (!amap_rdata[rid_r[COL_AW-1:0]]) begin
                out_st_nxt = ST_INACTIVE;
              end else begin
                amap_wr = '{en: 1'b1, row: rid_r[ID_W-1:COL_AW],
                            col: rid_r[COL_AW-1:0], val: 1'b0};
                if (count_r[CNT_W-1]) begin
                  out_st_nxt = ST_QFULL;
                end else begin
                  rq_wr_en   = 1'b1;
                  tail_nxt   = tail_r + 1'b1;
                  count_nxt  = count_r + 1'b1;
                  out_st_nxt = ST_OK;
                end
              end
            end
          end
          default: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_id_nxt    = rid_r;
              out_st_nxt    = ST_OK;
              state_nxt     = S_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_id_r <= out_id_nxt;
    out_st_r <= out_st_nxt;
    if (accept) begin
      act_r <= action_t'(in_action);
      rid_r <= in_request_id;
    end
  end

  idalloc_amap u_amap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (amap_rd_en),
    .rd_row  (amap_rd_row),
    .wr      (amap_wr),
    .rdata_r (amap_rdata)
  );

  idalloc_rq u_rq (
    .clk     (clk),
    .wr_en   (rq_wr_en),
    .wr_addr (tail_r),
    .wr_data (rid_r),
    .rd_en   (rq_rd_en),
    .rd_addr (head_r),
    .rdata_r (rq_rdata)
  );

  // queue occupancy agrees with the pointer distance
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[ID_W-1:0] == ID_W'(tail_r - head_r))
    else $error("recycle queue count out of step with pointers");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(POOL_SIZE))
    else $error("recycle queue count above pool size");

  a_fresh_max: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= CNT_W'(POOL_SIZE))
    else $error("fresh id counter beyond pool end");

  // a word is loaded into the result register only when it was free or drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_id_r) && $stable(out_st_r)))
    else $error("pending result overwritten");

endmodule

@@ rtl/core/idalloc_amap.sv @@
// active map memory: one row of id bits per address, bit writes, row valid bits
module idalloc_amap import idalloc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ROW_AW-1:0] rd_row,
  input  amap_wr_t          wr,
  output logic [ROW_W-1:0]  rdata_r
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_vld_r;
  logic [ROWS-1:0]  row_vld_nxt;

  always_comb begin
    row_vld_nxt = row_vld_r;
    if (wr.en) begin
      row_vld_nxt[wr.row] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else begin
      row_vld_r <= row_vld_nxt;
    end
  end

  // a row never written reads as all inactive, so its first write sets the whole row
  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (row_vld_r[wr.row]) begin
        mem[wr.row][wr.col] <= wr.val;
      end else begin
        mem[wr.row] <= ROW_W'(wr.val) << wr.col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= row_vld_r[rd_row] ? mem[rd_row] : '0;
    end
  end

endmodule

@@ rtl/core/idalloc_rq.sv @@
// recycle queue storage: released ids waiting for reuse
module idalloc_rq import idalloc_pkg::*; (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [ID_W-1:0] wr_addr,
  input  logic [ID_W-1:0] wr_data,
  input  logic            rd_en,
  input  logic [ID_W-1:0] rd_addr,
  output logic [ID_W-1:0] rdata_r
);

  logic [ID_W-1:0] mem [POOL_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

endmodule

@@ verif/tb_top.sv @@
// testbench for the id allocator: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_top import idalloc_pkg::*; ();

  localparam int HOLD_CYCLES = 120;
  localparam int QUIET_LIMIT = 1000;

  // tracks the id pool as the block should see it and the results it owes
  class id_grant_checker;
    logic [POOL_SIZE-1:0] active;
    logic [ID_W-1:0]      recycled [POOL_SIZE];
    int                   head;
    int                   tail;
    int                   count;
    int                   next_fresh;
    logic [ID_W-1:0]      want_id [$];
    status_t              want_status [$];
    int                   errors;

    function new();
      active     = '0;
      head       = 0;
      tail       = 0;
      count      = 0;
      next_fresh = 0;
      errors     = 0;
    endfunction

    function void owe(logic [ID_W-1:0] id, status_t st);
      want_id     = {want_id, id};
      want_status = {want_status, st};
    endfunction

    function void note_request(action_t act, logic [ID_W-1:0] rid);
      int gid;
      case (act)
        ACT_ALLOC: begin
          if (count > 0) begin
            gid   = recycled[head];
            head  = (head + 1) % POOL_SIZE;
            count = count - 1;
            active[gid] = 1'b1;
            owe(ID_W'(gid), ST_OK);
          end else begin
            while (next_fresh < POOL_SIZE && active[next_fresh])
              next_fresh++;
            if (next_fresh >= POOL_SIZE) begin
              owe('0, ST_EXHAUSTED);
            end else begin
              gid = next_fresh;
              next_fresh++;
              active[gid] = 1'b1;
              owe(ID_W'(gid), ST_OK);
            end
          end
        end
        ACT_CLAIM: begin
          if (int'(rid) >= POOL_SIZE) begin
            owe(rid, ST_INACTIVE);
          end else begin
            active[rid] = 1'b1;
            owe(rid, ST_OK);
          end
        end
        ACT_RELEASE: begin
          if (int'(rid) >= POOL_SIZE || !active[rid]) begin
            owe(rid, ST_INACTIVE);
          end else begin
            active[rid] = 1'b0;
            if (count >= POOL_SIZE) begin
              owe(rid, ST_QFULL);
            end else begin
              recycled[tail] = rid;
              tail  = (tail + 1) % POOL_SIZE;
              count = count + 1;
              owe(rid, ST_OK);
            end
          end
        end
        default: owe(rid, ST_OK);
      endcase
    endfunction

    function void check_result(logic [ID_W-1:0] id, logic [1:0] st);
      logic [ID_W-1:0] exp_id;
      status_t         exp_st;
      if (want_id.size() == 0) begin
        $error("unexpected result: result_id %0d, status %0d", id, st);
        errors++;
        return;
      end
      exp_id = want_id[0];
      exp_st = want_status[0];
      want_id.delete(0);
      want_status.delete(0);
      if (id !== exp_id) begin
        $error("result_id: expected %0d, got %0d", exp_id, id);
        errors++;
      end
      if (st !== exp_st) begin
        $error("status: expected %0d, got %0d", exp_st, st);
        errors++;
      end
    endfunction

    function int pending();
      return want_id.size();
    endfunction

    // some id that is active now, or any id if none is
    function logic [ID_W-1:0] pick_active();
      int n;
      int k;
      n = 0;
      for (int i = 0; i < POOL_SIZE; i++)
        if (active[i]) n++;
      if (n == 0) return ID_W'($urandom);
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < POOL_SIZE; i++) begin
        if (active[i]) begin
          if (k == 0) return ID_W'(i);
          k--;
        end
      end
      return '0;
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [1:0]      in_action;
  logic [ID_W-1:0] in_request_id;
  logic            out_valid;
  logic            out_ready;
  logic [ID_W-1:0] out_result_id;
  logic [1:0]      out_status;

  id_grant_checker grant_chk;
  int              words_sent;
  bit              steady;
  bit              hold_req;
  int              quiet_cycles;

  id_allocator_with_recycle_queue_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_request_id (in_request_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_id (out_result_id),
    .out_status    (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called and returns at a falling edge
  task automatic send_word(action_t act, logic [ID_W-1:0] rid);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_action     = act;
    in_request_id = rid;
    do @(posedge clk); while (!in_ready);
    grant_chk.note_request(act, rid);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic mixed_run(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        send_word(ACT_ALLOC, ID_W'($urandom));
      else if (r < 60)
        send_word(ACT_CLAIM, ID_W'($urandom));
      else if (r < 80)
        send_word(ACT_RELEASE, grant_chk.pick_active());
      else if (r < 95)
        send_word(ACT_RELEASE, ID_W'($urandom));
      else
        send_word(ACT_NOP, ID_W'($urandom));
    end
  endtask

  task automatic mixed_until(int target);
    while (words_sent < target) begin
      steady = ($urandom_range(0, 3) == 0);
      mixed_run(24);
    end
    steady = 1'b0;
  endtask

  initial begin
    grant_chk     = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_ALLOC;
    in_request_id = '0;
    out_ready     = 1'b0;
    words_sent    = 0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: first fresh id, claim of an active id, double release, unused action,
    // fresh scan skipping a claimed id, and the same id handed out twice after a re-claim
    send_word(ACT_ALLOC, 6'd63);
    send_word(ACT_CLAIM, 6'd63);
    send_word(ACT_CLAIM, 6'd0);
    send_word(ACT_RELEASE, 6'd63);
    send_word(ACT_RELEASE, 6'd63);
    send_word(ACT_RELEASE, 6'd42);
    send_word(ACT_NOP, 6'd63);
    send_word(ACT_NOP, 6'd0);
    send_word(ACT_ALLOC, 6'd0);
    send_word(ACT_CLAIM, 6'd1);
    send_word(ACT_ALLOC, 6'd21);
    send_word(ACT_CLAIM, 6'd5);
    send_word(ACT_RELEASE, 6'd5);
    send_word(ACT_CLAIM, 6'd5);
    send_word(ACT_ALLOC, 6'd0);
    send_word(ACT_RELEASE, 6'd5);
    send_word(ACT_ALLOC, 6'd0);
    send_word(ACT_RELEASE, 6'd0);
    send_word(ACT_RELEASE, 6'd2);
    send_word(ACT_ALLOC, 6'd0);
    send_word(ACT_ALLOC, 6'd0);
    send_word(ACT_ALLOC, 6'd0);

    mixed_until(60);

    // receiver holds off while the sender keeps pushing back to back
    hold_req = 1'b1;
    steady   = 1'b1;
    mixed_run(24);
    steady   = 1'b0;

    mixed_until(150);

    // claim/release pairs overflow the recycle queue
    for (int k = 0; k < POOL_SIZE + 3; k++) begin
      logic [ID_W-1:0] rid;
      rid = ID_W'($urandom);
      send_word(ACT_CLAIM, rid);
      send_word(ACT_RELEASE, rid);
    end

    mixed_until(330);

    // drain the queue and run the fresh counter off the end of the pool
    repeat (grant_chk.count + POOL_SIZE + 2) send_word(ACT_ALLOC, ID_W'($urandom));

    mixed_until(500);

    in_valid = 1'b0;
    while (grant_chk.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (grant_chk.errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = steady ? 0 : $urandom_range(0, 8);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      grant_chk.check_result(out_result_id, out_status);
    end
  end

  // no word moving on either side for too long means the block is stuck
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule

@@ sim.f @@
rtl/core/idalloc_pkg.sv
rtl/core/idalloc_amap.sv
rtl/core/idalloc_rq.sv
rtl/core/id_allocator_with_recycle_queue_top.sv
verif/tb_top.sv
